// ===== rtl/csem_pkg.sv =====
// Shared types, constants and codes for the counting semaphore block.
package csem_pkg;

  localparam int WAITER_DEPTH = 16;
  localparam int CNT_W        = $clog2(WAITER_DEPTH + 1);
  localparam int ID_W         = 16;
  localparam int COUNT_W      = 16;

  localparam logic [1:0] OP_TRY  = 2'd0;
  localparam logic [1:0] OP_WAIT = 2'd1;
  localparam logic [1:0] OP_POST = 2'd2;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_REFUSED   = 3'd1;
  localparam logic [2:0] ST_QUEUED    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_WOKEN     = 3'd4;
  localparam logic [2:0] ST_POSTED    = 3'd5;
  localparam logic [2:0] ST_SATURATED = 3'd6;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] requester_id;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] woken_id;
    logic            last;
  } rsp_t;

  // Control seen by every cell of the waiter row.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== rtl/counting_semaphore_with_waiters_unit.sv =====
// Top level of the counting semaphore with a waiter list.
//
// Requests enter on in_valid/in_ready as one word (opcode, requester_id).
// Results leave on out_valid/out_ready as words (status, woken_id, last).
// The count register is loaded through cfg_valid/cfg_ready, which also
// empties the waiter list; cfg_ready is always high, and a config word holds
// in_ready low in its cycle.
// Try, wait and a post that wakes nobody each give one result, registered
// in the output register when the request is taken; the next request can be taken
// in the cycle the result is shown, so these run at one request per cycle while the receiver keeps up.
// A post that raises the count from zero with N waiters stored gives N
// woken results from the head of the waiter row, one per cycle while the
// receiver keeps up, the first once the draining flag is set; no request is
// taken until the last of them is loaded into the output register.
// A stalled receiver holds the output word; requests and the drain wait
// for it. Reset clears the count, the waiter total and the output.
// Opcode 3 is taken and dropped without a result.
module counting_semaphore_with_waiters_unit import csem_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsp_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] count;
  logic [CNT_W-1:0]   total;
  logic               draining;
  logic [ID_W-1:0]    head_id;
  logic               slot_free;
  logic               cfg_fire;
  logic               in_fire;
  logic               drain_step;
  logic               append;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid;
  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = !draining && slot_free && !cfg_valid;
  assign in_fire    = in_valid && in_ready && !cfg_fire;
  assign drain_step = draining && slot_free && !cfg_fire;
  assign append     = in_fire && (in_data.opcode == OP_WAIT) && (count == '0)
                      && (total < CNT_W'(WAITER_DEPTH));

  csem_chain u_chain (
    .clk     (clk),
    .shift   (drain_step),
    .append  (append),
    .total   (total),
    .new_id  (in_data.requester_id),
    .head_id (head_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      draining  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire) begin
        count    <= cfg_data;
        total    <= '0;
        draining <= 1'b0;
      end else if (drain_step) begin
        out_valid         <= 1'b1;
        out_data.status   <= ST_WOKEN;
        out_data.woken_id <= head_id;
        out_data.last     <= (total == CNT_W'(1));
        total             <= total - CNT_W'(1);
        if (total == CNT_W'(1)) begin
          draining <= 1'b0;
        end
      end else if (in_fire) begin
        out_data.woken_id <= '0;
        out_data.last     <= 1'b1;
        case (in_data.opcode)
          OP_TRY: begin
            out_valid <= 1'b1;
            if (count != '0) begin
              count           <= count - COUNT_W'(1);
              out_data.status <= ST_GRANTED;
            end else begin
              out_data.status <= ST_REFUSED;
            end
          end
          OP_WAIT: begin
            out_valid <= 1'b1;
            if (count != '0) begin
              count           <= count - COUNT_W'(1);
              out_data.status <= ST_GRANTED;
            end else if (append) begin
              total           <= total + CNT_W'(1);
              out_data.status <= ST_QUEUED;
            end else begin
              out_data.status <= ST_FULL;
            end
          end
          OP_POST: begin
            if (count == '1) begin
              out_valid       <= 1'b1;
              out_data.status <= ST_SATURATED;
            end else begin
              count <= count + COUNT_W'(1);
              if ((count == '0) && (total != '0)) begin
                // release the stored waiters over the next cycles
                draining <= 1'b1;
              end else begin
                out_valid       <= 1'b1;
                out_data.status <= ST_POSTED;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/csem_cell.sv =====
// One waiter slot: holds an id, takes its neighbor's id on shift or a new id on load.
module csem_cell import csem_pkg::*; (
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  logic [ID_W-1:0] neighbor_id,
  input  logic [ID_W-1:0] new_id,
  output logic [ID_W-1:0] id
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      id <= neighbor_id;
    end else if (ctrl.load) begin
      id <= new_id;
    end
  end

endmodule

// ===== rtl/csem_chain.sv =====
// Row of waiter cells: append at the fill point, drain from the head by shifting.
module csem_chain import csem_pkg::*; (
  input  logic             clk,
  input  logic             shift,
  input  logic             append,
  input  logic [CNT_W-1:0] total,
  input  logic [ID_W-1:0]  new_id,
  output logic [ID_W-1:0]  head_id
);

  logic [ID_W-1:0] ids [WAITER_DEPTH];

  for (genvar i = 0; i < WAITER_DEPTH; i++) begin : g_cell
    cell_ctrl_t      ctrl;
    logic [ID_W-1:0] nbr;

    assign ctrl.shift = shift;
    // the cell at the current fill point takes the new id
    assign ctrl.load  = append && (total == CNT_W'(i));

    if (i == WAITER_DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ids[i+1];
    end

    csem_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .neighbor_id (nbr),
      .new_id      (new_id),
      .id          (ids[i])
    );
  end

  assign head_id = ids[0];

endmodule

// ===== rtl/csem_check.sv =====
// Port-level checks for the counting semaphore, bound to the top level.
module csem_check import csem_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_WOKEN) |-> (out_data.woken_id == '0))
    else $error("nonzero id on a result that wakes nobody");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_WOKEN) |-> out_data.last)
    else $error("single result without last");

  // no new request while a wake run is still going
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_WOKEN) && !out_data.last |-> !in_ready)
    else $error("request taken in the middle of a wake run");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind counting_semaphore_with_waiters_unit csem_check u_csem_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the counting semaphore with a waiter list.
module testbench;
  import csem_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int MAX_GAP = 19;
  localparam int LONG_HOLD = 150;
  localparam int SETTLE = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PLAN_ROWS = 21;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  op;
    logic [15:0] arg;
    logic [4:0]  reps;
    logic        typed;
    logic [2:0]  st;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  req_t               in_data;
  logic               out_valid;
  logic               out_ready;
  rsp_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  // Own copy of the semaphore state.
  logic [COUNT_W-1:0] units;
  logic [ID_W-1:0]    sleepers [WAITER_DEPTH];
  int                 sleeper_total;

  rsp_t      pending_results [$];
  rsp_t      want;
  plan_row_t plan [PLAN_ROWS];
  int        faults;
  int        cycles = 0;
  bit        tx_idle;
  bit        rx_idle;
  bit        hold_wanted;

  counting_semaphore_with_waiters_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic plan_row_t mk_row(row_kind_e kind, logic [1:0] op, logic [15:0] arg,
                                       logic [4:0] reps, logic typed, logic [2:0] st);
    plan_row_t row;
    row.kind = kind;
    row.op = op;
    row.arg = arg;
    row.reps = reps;
    row.typed = typed;
    row.st = st;
    return row;
  endfunction

  task automatic push_result(input bit keep, input logic [2:0] st, input logic [ID_W-1:0] id,
                             input bit fin);
    rsp_t w;
    w.status = st;
    w.woken_id = id;
    w.last = fin;
    if (keep) pending_results.push_back(w);
  endtask

  task automatic semaphore_step(input req_t r, input bit keep);
    int n;
    case (r.opcode)
      OP_TRY: begin
        if (units != '0) begin
          units = units - 1'b1;
          push_result(keep, ST_GRANTED, '0, 1'b1);
        end else begin
          push_result(keep, ST_REFUSED, '0, 1'b1);
        end
      end
      OP_WAIT: begin
        if (units != '0) begin
          units = units - 1'b1;
          push_result(keep, ST_GRANTED, '0, 1'b1);
        end else if (sleeper_total < WAITER_DEPTH) begin
          sleepers[sleeper_total] = r.requester_id;
          sleeper_total++;
          push_result(keep, ST_QUEUED, '0, 1'b1);
        end else begin
          push_result(keep, ST_FULL, '0, 1'b1);
        end
      end
      OP_POST: begin
        if (units == '1) begin
          push_result(keep, ST_SATURATED, '0, 1'b1);
        end else begin
          units = units + 1'b1;
          // A rise from zero releases the whole list, oldest first.
          if (units == 1 && sleeper_total > 0) begin
            for (n = 0; n < sleeper_total; n++)
              push_result(keep, ST_WOKEN, sleepers[n], n == sleeper_total - 1);
            sleeper_total = 0;
          end else begin
            push_result(keep, ST_POSTED, '0, 1'b1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] id, input bit typed,
                              input logic [2:0] st);
    int gap;
    req_t r;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    r.opcode = op;
    r.requester_id = id;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    semaphore_step(r, !typed);
    if (typed) push_result(1'b1, st, '0, 1'b1);
  endtask

  task automatic park_input;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_count(input logic [COUNT_W-1:0] v);
    park_input();
    drain_results();
    // Let a dropped opcode 3 word clear the pipe.
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    units = v;
    sleeper_total = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d woken_id %0h last %0b",
               out_data.status, out_data.woken_id, out_data.last);
        faults++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          faults++;
        end
        if (out_data.woken_id !== want.woken_id) begin
          $error("woken_id: expected %0h, actual %0h", want.woken_id, out_data.woken_id);
          faults++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_data.last);
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("counting_semaphore_with_waiters_unit verification failed");
      $finish;
    end
  end

  // Receiver: stall for a random gap after each word when rx_idle is set, or hold off for a long stretch on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_wanted || (out_valid && out_ready)) begin
        if (hold_wanted) begin
          hold_wanted = 1'b0;
          gap = LONG_HOLD;
        end else begin
          gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (gap > 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int i;
    int k;
    int ph;
    int done;
    int n;
    int pick;
    logic [1:0] op;
    logic [COUNT_W-1:0] start;
    bit paused;

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_wanted = 1'b0;
    faults = 0;
    units = '0;
    sleeper_total = 0;
    paused = 1'b0;

    plan[0]  = mk_row(ROW_REQ, OP_TRY,  16'h0000, 1,  1, ST_REFUSED);
    plan[1]  = mk_row(ROW_REQ, OP_WAIT, 16'hFFFF, 1,  1, ST_QUEUED);
    plan[2]  = mk_row(ROW_REQ, OP_WAIT, 16'h0000, 1,  1, ST_QUEUED);
    plan[3]  = mk_row(ROW_REQ, OP_NONE, 16'hAAAA, 1,  0, ST_GRANTED);
    plan[4]  = mk_row(ROW_REQ, OP_POST, 16'h5555, 1,  0, ST_GRANTED);
    plan[5]  = mk_row(ROW_REQ, OP_POST, 16'h0000, 1,  1, ST_POSTED);
    plan[6]  = mk_row(ROW_REQ, OP_TRY,  16'h0000, 1,  1, ST_GRANTED);
    plan[7]  = mk_row(ROW_REQ, OP_TRY,  16'h0000, 1,  1, ST_GRANTED);
    plan[8]  = mk_row(ROW_REQ, OP_TRY,  16'h0000, 1,  1, ST_REFUSED);
    plan[9]  = mk_row(ROW_CFG, OP_TRY,  16'hFFFE, 1,  0, ST_GRANTED);
    plan[10] = mk_row(ROW_REQ, OP_POST, 16'h0000, 1,  1, ST_POSTED);
    plan[11] = mk_row(ROW_REQ, OP_POST, 16'hFFFF, 1,  1, ST_SATURATED);
    plan[12] = mk_row(ROW_REQ, OP_WAIT, 16'h0000, 1,  1, ST_GRANTED);
    plan[13] = mk_row(ROW_CFG, OP_TRY,  16'h0000, 1,  0, ST_GRANTED);
    plan[14] = mk_row(ROW_REQ, OP_WAIT, 16'h8000, 16, 1, ST_QUEUED);
    plan[15] = mk_row(ROW_REQ, OP_WAIT, 16'h7FFF, 1,  1, ST_FULL);
    plan[16] = mk_row(ROW_REQ, OP_POST, 16'h0000, 1,  0, ST_GRANTED);
    plan[17] = mk_row(ROW_REQ, OP_TRY,  16'h0000, 1,  1, ST_GRANTED);
    plan[18] = mk_row(ROW_REQ, OP_POST, 16'h0000, 1,  1, ST_POSTED);
    plan[19] = mk_row(ROW_CFG, OP_TRY,  16'hFFFF, 1,  0, ST_GRANTED);
    plan[20] = mk_row(ROW_REQ, OP_POST, 16'h0000, 1,  1, ST_SATURATED);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        load_count(plan[i].arg);
      end else begin
        for (k = 0; k < plan[i].reps; k++)
          send_request(plan[i].op, ID_W'(plan[i].arg + k), plan[i].typed, plan[i].st);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 2:    start = '0;
        1:       start = 16'd1;
        3:       start = COUNT_W'($urandom_range(0, 3));
        4:       start = '1;
        5:       start = 16'hFFFF - COUNT_W'($urandom_range(0, 3));
        6:       start = COUNT_W'($urandom_range(0, 65535));
        default: start = 16'd2;
      endcase
      load_count(start);
      tx_idle = ph[0];
      rx_idle = ph[1];
      // Stall the output while words keep coming so the input backs up.
      if (ph == 2) hold_wanted = 1'b1;
      done = 0;
      while (done < 10 || (ph == 3 && !paused)) begin
        if (ph == 3 && done > 0 && !paused) begin
          park_input();
          drain_results();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          // Queue a burst of waiters, then post to wake them.
          n = $urandom_range(1, WAITER_DEPTH + 2);
          repeat (n) send_request(OP_WAIT, ID_W'($urandom_range(0, 65535)), 1'b0, ST_GRANTED);
          send_request(OP_POST, ID_W'($urandom_range(0, 65535)), 1'b0, ST_GRANTED);
          done += n + 1;
        end else if (pick < 9) begin
          case ($urandom_range(0, 2))
            0:       op = OP_TRY;
            1:       op = OP_WAIT;
            default: op = OP_POST;
          endcase
          send_request(op, ID_W'($urandom_range(0, 65535)), 1'b0, ST_GRANTED);
          done++;
        end else begin
          send_request(OP_NONE, ID_W'($urandom_range(0, 65535)), 1'b0, ST_GRANTED);
        end
      end
    end

    park_input();
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (faults == 0)
      $display("counting_semaphore_with_waiters_unit verification clean");
    else
      $display("counting_semaphore_with_waiters_unit verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/csem_pkg.sv
rtl/csem_cell.sv
rtl/csem_chain.sv
rtl/counting_semaphore_with_waiters_unit.sv
rtl/csem_check.sv
tb/testbench.sv
